// ----- sv/ccc_pkg.sv -----
// ---------------------------------------------------------------------------
// ccc_pkg - shared types and constants of the cylinder cell classifier
// Command codes between controller and datapath, register indexes and the
// class codes of a result.
// ---------------------------------------------------------------------------
package ccc_pkg;

  localparam int CCC_AXIS_CELLS_MAX = 1024;

  localparam int POS_W   = 10;
  localparam int CFG_W   = 32;
  localparam int LAYER_W = 11;
  localparam int NUM_W   = 30;
  localparam int FLAG_W  = 8;
  localparam int CLASS_W = 2;
  localparam int ADDR_W  = 3;

  localparam logic [NUM_W-1:0]  COUNT_MAX = {NUM_W{1'b1}};
  localparam logic [FLAG_W-1:0] FLAG_ALL  = 8'hFF;
  localparam logic [FLAG_W-1:0] FLAG_LOW  = 8'hF0;
  localparam logic [FLAG_W-1:0] FLAG_HIGH = 8'h0F;
  localparam logic [FLAG_W-1:0] BIT_C00   = 8'h11;
  localparam logic [FLAG_W-1:0] BIT_C10   = 8'h22;
  localparam logic [FLAG_W-1:0] BIT_C01   = 8'h44;
  localparam logic [FLAG_W-1:0] BIT_C11   = 8'h88;

  localparam logic [CFG_W-1:0]   CS_RESET     = 32'h0001_0000;
  localparam logic [CFG_W-1:0]   EXTENT_RESET = 32'h0;
  localparam logic [LAYER_W-1:0] LAYERS_RESET = 11'd1;

  typedef enum logic [ADDR_W-1:0] {
    REG_CELL_SIZE_X = 3'd0,
    REG_CELL_SIZE_Y = 3'd1,
    REG_EXTENT_X    = 3'd2,
    REG_EXTENT_Y    = 3'd3,
    REG_LAYERS_Z    = 3'd4
  } reg_idx_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE     = 2'd0,
    CLS_INTERIOR = 2'd1,
    CLS_BOUNDARY = 2'd2,
    CLS_ERROR    = 2'd3
  } cell_class_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,      // capture the input transaction
    OP_E2,        // extent squared
    OP_MULPOS,    // corner index times cell size
    OP_ABSDIFF,   // |2 n cs - E| and its range check
    OP_SQUARE,    // axis term squared
    OP_CORNER,    // one corner test
    OP_CLASSIFY   // classify and publish the result
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;  // axis term: [2] y axis, [1:0] corner; corner test: [3:2] u, [1:0] v
  } cmd_t;

endpackage

// ----- sv/ccc_ctrl.sv -----
// ---------------------------------------------------------------------------
// ccc_ctrl - sequencer of the cylinder cell classifier
// Walks one transaction through extent square, eight axis terms and sixteen
// corner tests, then publishes into the output register.
// ---------------------------------------------------------------------------
module ccc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output ccc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_SQE, S_AXIS, S_CORNER, S_CLASS} state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = ccc_pkg::OP_NOP;
    cmd.idx       = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = ccc_pkg::OP_LOAD;
          state_nxt = S_SQE;
        end
      end
      S_SQE: begin
        cmd.op    = ccc_pkg::OP_E2;
        state_nxt = S_AXIS;
        step_nxt  = '0;
        phase_nxt = '0;
      end
      S_AXIS: begin
        case (phase_r)
          2'd0:    cmd.op = ccc_pkg::OP_MULPOS;
          2'd1:    cmd.op = ccc_pkg::OP_ABSDIFF;
          default: cmd.op = ccc_pkg::OP_SQUARE;
        endcase
        if (phase_r == 2'd2) begin
          phase_nxt = '0;
          step_nxt  = step_r + 4'd1;
          if (step_r == 4'd7) begin
            state_nxt = S_CORNER;
            step_nxt  = '0;
          end
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      S_CORNER: begin
        cmd.op   = ccc_pkg::OP_CORNER;
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd15) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        if (out_free) begin
          cmd.op        = ccc_pkg::OP_CLASSIFY;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SQE))
    else $error("accepted transaction did not start the sequence");
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ccc_pkg::OP_CLASSIFY) |-> (!out_valid_r || out_tready))
    else $error("result published over an untaken one");
  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ccc_pkg::OP_CLASSIFY) |=> out_tvalid)
    else $error("published result not shown");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AXIS) |-> (phase_r != 2'd3))
    else $error("axis phase out of range");

endmodule

// ----- sv/ccc_dp.sv -----
// ---------------------------------------------------------------------------
// ccc_dp - datapath of the cylinder cell classifier
// Config registers, one shared 32x32 multiplier, axis term store, corner
// bits, neighbour classification, cell counter and output register.
// ---------------------------------------------------------------------------
module ccc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ccc_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [ccc_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [ccc_pkg::POS_W-1:0]    in_pos_x,
  input  logic [ccc_pkg::POS_W-1:0]    in_pos_y,
  input  logic [ccc_pkg::POS_W-1:0]    in_pos_z,
  input  logic                         in_restart,
  input  ccc_pkg::cmd_t                cmd,
  output logic [ccc_pkg::FLAG_W-1:0]   out_flag,
  output logic [ccc_pkg::CLASS_W-1:0]  out_class,
  output logic [ccc_pkg::NUM_W-1:0]    out_number
);

  logic [31:0] cs_x_r, cs_y_r, ext_x_r, ext_y_r;
  logic [10:0] layers_r;
  logic [9:0]  px_r, py_r, pz_r;
  logic [29:0] count_r;
  logic [63:0] prod_r, e2_r, mul_p;
  logic [31:0] mul_a, mul_b, d_r;
  logic        ok_r;
  logic [63:0] sqx_r [4];
  logic [63:0] sqy_r [4];
  logic [3:0]  okx_r, oky_r;
  logic [15:0] cb_r;
  logic [7:0]  flag_r;
  logic [1:0]  class_r;
  logic [29:0] num_r;

  logic [10:0] n_idx;
  logic [43:0] p_w, e_w, d_w;
  logic [64:0] sum_w;
  logic        corner_bit;
  logic [7:0]  own_flag;
  logic        inner;

  // corner index along the active axis: position - 1 + u
  always_comb begin
    if (cmd.idx[2]) n_idx = {1'b0, py_r} + {9'd0, cmd.idx[1:0]} - 11'd1;
    else            n_idx = {1'b0, px_r} + {9'd0, cmd.idx[1:0]} - 11'd1;
  end

  always_comb begin
    case (cmd.op)
      ccc_pkg::OP_E2: begin
        mul_a = ext_x_r;
        mul_b = ext_x_r;
      end
      ccc_pkg::OP_MULPOS: begin
        mul_a = {21'd0, n_idx};
        mul_b = cmd.idx[2] ? cs_y_r : cs_x_r;
      end
      default: begin
        mul_a = d_r;
        mul_b = d_r;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign p_w   = {prod_r[42:0], 1'b0};
  assign e_w   = {12'd0, ext_x_r};
  assign d_w   = (p_w >= e_w) ? (p_w - e_w) : (e_w - p_w);
  assign sum_w = {1'b0, sqx_r[cmd.idx[3:2]]} + {1'b0, sqy_r[cmd.idx[1:0]]};
  assign corner_bit = okx_r[cmd.idx[3:2]] && oky_r[cmd.idx[1:0]] &&
                      (sum_w < {1'b0, e2_r});

  // flag of the neighbour at offsets a-1, b-1, c-1; zero when outside the grid
  function automatic logic [7:0] nb_flag(input int a, input int b, input int c);
    int          xi, yi, zi;
    logic [7:0]  f;
    xi = int'(px_r) + a - 1;
    yi = int'(py_r) + b - 1;
    zi = int'(pz_r) + c - 1;
    f  = '0;
    if (cb_r[a*4+b])         f = f | ccc_pkg::BIT_C00;
    if (cb_r[(a+1)*4+b])     f = f | ccc_pkg::BIT_C10;
    if (cb_r[a*4+b+1])       f = f | ccc_pkg::BIT_C01;
    if (cb_r[(a+1)*4+b+1])   f = f | ccc_pkg::BIT_C11;
    if (xi < 0 || yi < 0 || zi < 0 || xi >= ccc_pkg::CCC_AXIS_CELLS_MAX ||
        yi >= ccc_pkg::CCC_AXIS_CELLS_MAX || zi >= ccc_pkg::CCC_AXIS_CELLS_MAX ||
        zi >= int'(layers_r)) begin
      f = '0;
    end else if (zi == 0) begin
      f = f & ccc_pkg::FLAG_LOW;
    end else if (zi == int'(layers_r) - 1) begin
      f = f & ccc_pkg::FLAG_HIGH;
    end
    return f;
  endfunction

  always_comb begin
    logic [7:0] nf;
    own_flag = nb_flag(1, 1, 1);
    inner    = 1'b1;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int c = 0; c < 3; c++) begin
          nf = nb_flag(a, b, c);
          if (nf != '0 && nf != ccc_pkg::FLAG_ALL) inner = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_x_r   <= ccc_pkg::CS_RESET;
      cs_y_r   <= ccc_pkg::CS_RESET;
      ext_x_r  <= ccc_pkg::EXTENT_RESET;
      ext_y_r  <= ccc_pkg::EXTENT_RESET;
      layers_r <= ccc_pkg::LAYERS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        ccc_pkg::REG_CELL_SIZE_X: cs_x_r   <= cfg_wdata;
        ccc_pkg::REG_CELL_SIZE_Y: cs_y_r   <= cfg_wdata;
        ccc_pkg::REG_EXTENT_X:    ext_x_r  <= cfg_wdata;
        ccc_pkg::REG_EXTENT_Y:    ext_y_r  <= cfg_wdata;
        ccc_pkg::REG_LAYERS_Z:    layers_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.op == ccc_pkg::OP_LOAD && in_restart) begin
      count_r <= '0;
    end else if (cmd.op == ccc_pkg::OP_CLASSIFY && ext_x_r == ext_y_r &&
                 own_flag != '0 && count_r != ccc_pkg::COUNT_MAX) begin
      count_r <= count_r + 30'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ccc_pkg::OP_LOAD: begin
        px_r <= in_pos_x;
        py_r <= in_pos_y;
        pz_r <= in_pos_z;
      end
      ccc_pkg::OP_E2:     e2_r   <= mul_p;
      ccc_pkg::OP_MULPOS: prod_r <= mul_p;
      ccc_pkg::OP_ABSDIFF: begin
        d_r  <= d_w[31:0];
        ok_r <= (d_w < e_w);
      end
      ccc_pkg::OP_SQUARE: begin
        if (cmd.idx[2]) begin
          sqy_r[cmd.idx[1:0]] <= mul_p;
          oky_r[cmd.idx[1:0]] <= ok_r;
        end else begin
          sqx_r[cmd.idx[1:0]] <= mul_p;
          okx_r[cmd.idx[1:0]] <= ok_r;
        end
      end
      ccc_pkg::OP_CORNER: cb_r[cmd.idx] <= corner_bit;
      ccc_pkg::OP_CLASSIFY: begin
        if (ext_x_r != ext_y_r) begin
          flag_r  <= '0;
          class_r <= ccc_pkg::CLS_ERROR;
          num_r   <= '0;
        end else if (own_flag == '0) begin
          flag_r  <= '0;
          class_r <= ccc_pkg::CLS_NONE;
          num_r   <= '0;
        end else begin
          flag_r  <= own_flag;
          class_r <= (own_flag == ccc_pkg::FLAG_ALL && inner) ?
                     ccc_pkg::CLS_INTERIOR : ccc_pkg::CLS_BOUNDARY;
          num_r   <= count_r;
        end
      end
      default: ;
    endcase
  end

  assign out_flag   = flag_r;
  assign out_class  = class_r;
  assign out_number = num_r;

endmodule

// ----- sv/cylinder_cell_classifier.sv -----
// ---------------------------------------------------------------------------
// cylinder_cell_classifier - grid cell classifier against a z-axis cylinder
// Tests a cell's xy corners against the circle centred in the extent and
// classifies it as absent, interior, boundary or error, numbering created cells.
// ---------------------------------------------------------------------------
//  channel | ports                       | contents
//  in      | in_tvalid/tready/tdata/tuser| tdata: pos_x, pos_y, pos_z; tuser: restart_scan
//  out     | out_tvalid/tready/tdata/tuser| tdata: node_flag, cell_number; tuser: cell_class
//  cfg     | cfg_we/cfg_addr/cfg_wdata   | register write, no read-back
//
//  After acceptance a transaction runs through one extent square, eight axis terms
//  (each a position product, absolute difference and square), sixteen corner tests on
//  the single shared 32x32 multiplier and comparator, then a classify step.
//  A new transaction is taken the cycle after the result is published, even
//  while that result still waits in the output register.
//  Reset (rst_n low, synchronous) restores the register defaults and the counter.
// ---------------------------------------------------------------------------
module cylinder_cell_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pos_x[9:0], pos_y[19:10], pos_z[29:20], zero
  input  logic        in_tuser,   // restart_scan
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // node_flag[7:0], cell_number[37:8], zero
  output logic [1:0]  out_tuser   // cell_class
);

  ccc_pkg::cmd_t cmd;
  logic [7:0]    flag;
  logic [1:0]    cls;
  logic [29:0]   num;

  ccc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ccc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_pos_x   (in_tdata[9:0]),
    .in_pos_y   (in_tdata[19:10]),
    .in_pos_z   (in_tdata[29:20]),
    .in_restart (in_tuser),
    .cmd        (cmd),
    .out_flag   (flag),
    .out_class  (cls),
    .out_number (num)
  );

  assign out_tdata = {2'b00, num, flag};
  assign out_tuser = cls;

endmodule

// ----- verif/ccc_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccc_checker - result checker for the cylinder cell classifier
// Watches the config port and both streams, predicts each cell's flag, class
// and number from its own copy of the registers, and compares in order.
// ---------------------------------------------------------------------------
module ccc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [ccc_pkg::FLAG_W-1:0] flag;
    ccc_pkg::cell_class_t       cls;
    logic [ccc_pkg::NUM_W-1:0]  num;
  } cell_result_t;

  logic [ccc_pkg::CFG_W-1:0]   csx, csy, ext_x, ext_y;
  logic [ccc_pkg::LAYER_W-1:0] layers;
  logic [ccc_pkg::NUM_W-1:0]   created;
  cell_result_t                cell_q[$];

  assign pending = cell_q.size();

  // Exact corner test: (2n cs - E)^2 + (2m cs - E)^2 < E^2
  function automatic bit corner_in(longint unsigned n, longint unsigned m);
    logic [127:0] e, px, py, dx, dy;
    e  = ext_x;
    px = 128'(2) * n * csx;
    py = 128'(2) * m * csy;
    dx = (px >= e) ? px - e : e - px;
    dy = (py >= e) ? py - e : e - py;
    return dx * dx + dy * dy < e * e;
  endfunction

  function automatic logic [7:0] flag_at(int i, int j, int k);
    logic [7:0] f;
    f = '0;
    if (i < 0 || j < 0 || k < 0) return '0;
    if (i >= ccc_pkg::CCC_AXIS_CELLS_MAX || j >= ccc_pkg::CCC_AXIS_CELLS_MAX) return '0;
    if (k >= ccc_pkg::CCC_AXIS_CELLS_MAX || k >= int'(layers)) return '0;
    if (corner_in(i, j))         f |= ccc_pkg::BIT_C00;
    if (corner_in(i + 1, j))     f |= ccc_pkg::BIT_C10;
    if (corner_in(i, j + 1))     f |= ccc_pkg::BIT_C01;
    if (corner_in(i + 1, j + 1)) f |= ccc_pkg::BIT_C11;
    if (k == 0) f &= ccc_pkg::FLAG_LOW;
    else if (k == int'(layers) - 1) f &= ccc_pkg::FLAG_HIGH;
    return f;
  endfunction

  function automatic cell_result_t classify(int x, int y, int z, bit restart);
    cell_result_t r;
    logic [7:0]   nf;
    bit           inner;
    r = '0;
    if (restart) created = '0;
    if (ext_x != ext_y) begin
      r.cls = ccc_pkg::CLS_ERROR;
      return r;
    end
    r.flag = flag_at(x, y, z);
    r.cls  = ccc_pkg::CLS_NONE;
    if (r.flag != 0) begin
      r.cls = ccc_pkg::CLS_BOUNDARY;
      if (r.flag == ccc_pkg::FLAG_ALL) begin
        inner = 1;
        for (int a = -1; a <= 1; a++)
          for (int b = -1; b <= 1; b++)
            for (int c = -1; c <= 1; c++) begin
              nf = flag_at(x + a, y + b, z + c);
              if (nf != 0 && nf != ccc_pkg::FLAG_ALL) inner = 0;
            end
        if (inner) r.cls = ccc_pkg::CLS_INTERIOR;
      end
      r.num = created;
      if (created != ccc_pkg::COUNT_MAX) created++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cell_result_t exp_r, got;
    if (!rst_n) begin
      csx <= ccc_pkg::CS_RESET; csy <= ccc_pkg::CS_RESET;
      ext_x <= ccc_pkg::EXTENT_RESET; ext_y <= ccc_pkg::EXTENT_RESET;
      layers <= ccc_pkg::LAYERS_RESET;
      created = '0;
      fail_count <= 0;
      cell_q.delete();
    end else begin
      if (cfg_we) begin
        case (ccc_pkg::reg_idx_t'(cfg_addr))
          ccc_pkg::REG_CELL_SIZE_X: csx    <= cfg_wdata;
          ccc_pkg::REG_CELL_SIZE_Y: csy    <= cfg_wdata;
          ccc_pkg::REG_EXTENT_X:    ext_x  <= cfg_wdata;
          ccc_pkg::REG_EXTENT_Y:    ext_y  <= cfg_wdata;
          ccc_pkg::REG_LAYERS_Z:    layers <= cfg_wdata[ccc_pkg::LAYER_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        cell_q.insert(cell_q.size(),
                      classify(in_tdata[9:0], in_tdata[19:10], in_tdata[29:20],
                               in_tuser));
      if (out_tvalid && out_tready) begin
        got.flag = out_tdata[7:0];
        got.num  = out_tdata[37:8];
        got.cls  = ccc_pkg::cell_class_t'(out_tuser);
        if (cell_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected transaction: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = cell_q.pop_front();
          if (got != exp_r) begin
            if (fail_count < 10)
              $display("mismatch: exp flag %h cls %0d num %0d, got flag %h cls %0d num %0d",
                       exp_r.flag, exp_r.cls, exp_r.num, got.flag, got.cls, got.num);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - stimulus for the cylinder cell classifier
// Walks several register settings, sends directed then random cells under
// varying back-pressure, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module testbench;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid, in_tready, in_tuser;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count, pending;
  int          send_idle, recv_stall;
  longint      cycles;

  cylinder_cell_classifier u_top (.*);

  ccc_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2_000_000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall);

  // write enable stays up across back-to-back writes; setup drops it
  task automatic write_reg(ccc_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
  endtask

  // tvalid stays up after acceptance so the next cell can follow directly
  task automatic send_cell(int x, int y, int z, bit restart);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {2'b0, 10'(z), 10'(y), 10'(x)};
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic setup(logic [31:0] cx, logic [31:0] cy, logic [31:0] ex,
                       logic [31:0] ey, int nz);
    drain();
    write_reg(ccc_pkg::REG_CELL_SIZE_X, cx);
    write_reg(ccc_pkg::REG_CELL_SIZE_Y, cy);
    write_reg(ccc_pkg::REG_EXTENT_X, ex);
    write_reg(ccc_pkg::REG_EXTENT_Y, ey);
    write_reg(ccc_pkg::REG_LAYERS_Z, nz);
    cfg_we <= 0;
  endtask

  // mostly in-grid positions around the circle, some anywhere
  task automatic random_cells(int count, int span, int nz);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 8)
        send_cell($urandom_range(span), $urandom_range(span), $urandom_range(nz),
                  $urandom_range(49) == 0);
      else
        send_cell($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1));
    end
  endtask

  initial begin
    cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
    in_tvalid = 0; in_tdata = '0; in_tuser = 0;
    out_tready = 0; send_idle = 0; recv_stall = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset registers: extent zero, every corner test false
    send_cell(0, 0, 0, 0);
    send_cell(1023, 1023, 1023, 1);
    // 8-cell-wide circle, 6 layers
    setup(32'h1_0000, 32'h1_0000, 32'h8_0000, 32'h8_0000, 6);
    for (int k = 0; k < 6; k++) send_cell(3, 3, k, k == 0);
    send_cell(0, 0, 2, 0);
    send_cell(7, 4, 2, 0);
    send_cell(3, 3, 6, 0);
    send_cell(1023, 3, 2, 0);
    send_cell(3, 1023, 2, 0);
    send_cell(4, 2, 3, 0);
    // unequal extents
    setup(32'h1_0000, 32'h1_0000, 32'h8_0000, 32'h8_0001, 6);
    send_cell(3, 3, 2, 1);
    send_cell(3, 3, 2, 0);
    // extremes: zero extent, huge cells, huge extent, max layers
    setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1024);
    send_cell(0, 0, 0, 0);
    send_cell(1, 0, 1023, 0);
    send_cell(0, 0, 500, 0);
    setup(32'd1, 32'd1, 32'd0, 32'd0, 1);
    send_cell(0, 0, 0, 0);
    setup(32'd1, 32'd1, 32'd2048, 32'd2048, 1024);
    send_cell(512, 512, 1023, 0);
    send_cell(1023, 1023, 1022, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 66; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 66; end
        default: begin send_idle = 9; recv_stall = 9; end
      endcase
      setup(32'h1_0000, 32'h1_8000, 32'hC_0000, 32'hC_0000, 8);
      random_cells(150, 12, 8);
      setup($urandom_range(32'h1_0000, 32'h4000), $urandom_range(32'h1_0000, 32'h4000),
            32'h10_0000, ($urandom_range(19) == 0) ? 32'h10_0001 : 32'h10_0000,
            $urandom_range(1, 12));
      random_cells(150, 70, 12);
    end

    drain();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
